// File: hdl/rtt_pkg.sv
package rtt_pkg;
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [2:0] FUNC_CLEAR  = 3'd0;
   localparam logic [2:0] FUNC_PUSH   = 3'd1;
   localparam logic [2:0] FUNC_POP    = 3'd2;
   localparam logic [2:0] FUNC_SEARCH = 3'd3;
   localparam logic [2:0] FUNC_REMOVE = 3'd4;
   localparam logic [2:0] FUNC_TICK   = 3'd5;

   localparam logic [2:0] KIND_DONE    = 3'd0;
   localparam logic [2:0] KIND_RESEND  = 3'd1;
   localparam logic [2:0] KIND_TIMEOUT = 3'd2;
   localparam logic [2:0] KIND_POPPED  = 3'd3;
   localparam logic [2:0] KIND_FOUND   = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NOTFOUND = 2'd1;
   localparam logic [1:0] STAT_FULL     = 2'd2;

   localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  mtype;
      logic [31:0] wait_t;
      logic [7:0]  sends;
      logic [31:0] reload;
   } slot_type;

   typedef struct packed {
      logic [15:0] id;
      logic [3:0]  mtype;
   } expired_type;
endpackage

// File: hdl/retransmit_timer_table.sv
// channel  | ports                                   | beat
// request  | start, busy, req_*                      | start & !busy
// response | rsp_valid, rsp_*                        | rsp_valid, one cycle
//
// one item is taken at a time; busy holds until its last result, for a pop until its shift ends
// clear, push, unknown, and pop/search/remove on an empty table: a single done beat
// pop: walks every entry, reports the head; search: walks up to the first match; remove: walks all
// tick: walks every entry, then one timeout beat per expired entry and a done beat
// the walks use one read and one write port on the slot memory, which has a registered read,
// and read one entry per cycle
// reset (synchronous) empties the table and zeroes the stored time
// results cannot be stalled; each shows for exactly one cycle
module retransmit_timer_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_packet_id,
   input  logic [3:0]  req_msg_type,
   input  logic [7:0]  req_send_count,
   input  logic [31:0] req_initial_wait,
   input  logic [31:0] req_reload_time,
   input  logic [31:0] req_sys_time,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_entry_id,
   output logic [3:0]  rsp_entry_type,
   output logic [7:0]  rsp_sends_left,
   output logic [31:0] rsp_wait_left,
   output logic [1:0]  rsp_status,
   output logic        rsp_is_empty,
   output logic        rsp_last
);
   import rtt_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WALK   = 3'd1;  // read stream over the table
   localparam logic [2:0] ST_EXP    = 3'd2;  // emit deferred timeouts
   localparam logic [2:0] ST_FINAL  = 3'd3;  // closing done beat
   localparam logic [2:0] ST_EXPRD  = 3'd4;  // expired buffer read latency

   logic [2:0]       state_ff, state_in;
   logic [2:0]       func_ff, func_in;
   logic [15:0]      key_id_ff, key_id_in;
   logic [3:0]       key_type_ff, key_type_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [31:0]      last_time_ff, last_time_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;    // next address issued
   logic             rd_vld_ff, rd_vld_in;    // data for rd_idx arrives now
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;    // compaction write pointer
   logic             found_ff, found_in;      // remove: match already seen
   logic [CNT_W-1:0] nexp_ff, nexp_in;
   logic [CNT_W-1:0] exp_ptr_ff, exp_ptr_in;
   logic [1:0]       fin_status_ff, fin_status_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_kind_ff, rsp_kind_in;
   slot_type         rsp_slot_ff, rsp_slot_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   slot_type         ram_wdata, ram_rdata;
   logic             exp_we;
   logic [IDX_W-1:0] exp_waddr, exp_raddr;
   expired_type      exp_wdata, exp_rdata;

   rtt_slot_ram u_slot (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rtt_exp_ram u_exp (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (exp_waddr),
      .wr_data (exp_wdata),
      .rd_addr (exp_raddr),
      .rd_data (exp_rdata)
   );

   logic             accept;
   logic             key_hit;
   logic             expire;
   logic [7:0]       dec_sends;
   slot_type         upd;
   logic             walk_done;

   assign accept  = start && (state_ff == ST_IDLE);
   assign key_hit = (ram_rdata.id == key_id_ff) && (ram_rdata.mtype == key_type_ff);
   assign expire  = elapsed_ff >= ram_rdata.wait_t;
   assign dec_sends = (ram_rdata.sends != 8'd0) ? ram_rdata.sends - 8'd1 : 8'd0;

   always_comb begin
      upd = ram_rdata;
      if (expire) begin
         upd.sends  = dec_sends;
         upd.wait_t = ram_rdata.reload;
      end else begin
         upd.wait_t = ram_rdata.wait_t - elapsed_ff;
      end
   end

   assign walk_done = rd_vld_ff && (rd_idx_ff + 1'b1 == total_ff);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_id_in     = key_id_ff;
      key_type_in   = key_type_ff;
      elapsed_in    = elapsed_ff;
      total_in      = total_ff;
      last_time_in  = last_time_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      found_in      = found_ff;
      nexp_in       = nexp_ff;
      exp_ptr_in    = exp_ptr_ff;
      fin_status_in = fin_status_ff;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_DONE;
      rsp_slot_in   = '0;
      rsp_status_in = STAT_OK;
      rsp_last_in   = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = wr_ptr_ff[IDX_W-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = rd_ptr_ff[IDX_W-1:0];
      exp_we        = 1'b0;
      exp_waddr     = nexp_ff[IDX_W-1:0];
      exp_wdata     = '{id: ram_rdata.id, mtype: ram_rdata.mtype};
      exp_raddr     = exp_ptr_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in     = req_func;
               key_id_in   = req_packet_id;
               key_type_in = req_msg_type;
               rd_ptr_in   = '0;
               wr_ptr_in   = '0;
               found_in    = 1'b0;
               nexp_in     = '0;
               exp_ptr_in  = '0;
               fin_status_in = STAT_OK;
               state_in    = ST_FINAL;
               case (req_func)
                  FUNC_CLEAR: begin
                     total_in     = '0;
                     last_time_in = req_sys_time;
                  end
                  FUNC_PUSH: begin
                     if (total_ff >= CNT_W'(DEPTH)) begin
                        fin_status_in = STAT_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = total_ff[IDX_W-1:0];
                        ram_wdata = '{id: req_packet_id, mtype: req_msg_type,
                                      wait_t: req_initial_wait, sends: req_send_count,
                                      reload: req_reload_time};
                        total_in  = total_ff + 1'b1;
                     end
                  end
                  FUNC_POP, FUNC_SEARCH, FUNC_REMOVE: begin
                     if (total_ff == '0) begin
                        fin_status_in = STAT_NOTFOUND;
                     end else begin
                        state_in  = ST_WALK;
                        ram_raddr = '0;
                        rd_ptr_in = CNT_W'(1);
                        rd_vld_in = 1'b1;
                        rd_idx_in = '0;
                     end
                  end
                  FUNC_TICK: begin
                     if (last_time_ff <= req_sys_time) begin
                        elapsed_in = req_sys_time - last_time_ff;
                     end else begin
                        elapsed_in = TIME_MAX - last_time_ff + req_sys_time;
                     end
                     last_time_in = req_sys_time;
                     if (total_ff != '0) begin
                        state_in  = ST_WALK;
                        ram_raddr = '0;
                        rd_ptr_in = CNT_W'(1);
                        rd_vld_in = 1'b1;
                        rd_idx_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // keep streaming reads; one write per cycle lags behind
            if (rd_ptr_ff < total_ff) begin
               rd_vld_in = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               case (func_ff)
                  FUNC_POP: begin
                     // shift entry i to i-1; report head
                     if (rd_idx_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_POPPED;
                        rsp_slot_in  = ram_rdata;
                        rsp_last_in  = 1'b1;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = IDX_W'(rd_idx_ff - 1'b1);
                     end
                     if (walk_done) begin
                        total_in = total_ff - 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  FUNC_SEARCH: begin
                     if (key_hit) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_FOUND;
                        rsp_slot_in  = ram_rdata;
                        rsp_last_in  = 1'b1;
                        rd_vld_in    = 1'b0;
                        state_in     = ST_IDLE;
                     end else if (walk_done) begin
                        fin_status_in = STAT_NOTFOUND;
                        rd_vld_in     = 1'b0;
                        state_in      = ST_FINAL;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (found_ff) begin
                        ram_we    = 1'b1;
                        ram_waddr = IDX_W'(rd_idx_ff - 1'b1);
                     end else if (key_hit) begin
                        found_in = 1'b1;
                     end
                     if (walk_done) begin
                        state_in = ST_FINAL;
                        if (found_ff || key_hit) begin
                           total_in = total_ff - 1'b1;
                        end else begin
                           fin_status_in = STAT_NOTFOUND;
                        end
                     end
                  end
                  default: begin
                     // tick
                     if (expire && dec_sends == 8'd0) begin
                        exp_we  = 1'b1;
                        nexp_in = nexp_ff + 1'b1;
                     end else begin
                        ram_we    = 1'b1;
                        ram_wdata = upd;
                        wr_ptr_in = wr_ptr_ff + 1'b1;
                        if (expire) begin
                           rsp_valid_in = 1'b1;
                           rsp_kind_in  = KIND_RESEND;
                           rsp_slot_in  = upd;
                        end
                     end
                     if (walk_done) begin
                        total_in = wr_ptr_in;
                        exp_raddr = '0;
                        exp_ptr_in = '0;
                        state_in = (nexp_in != '0) ? ST_EXPRD : ST_FINAL;
                     end
                  end
               endcase
            end
         end
         ST_EXPRD: begin
            exp_raddr  = exp_ptr_ff[IDX_W-1:0];
            exp_ptr_in = exp_ptr_ff + 1'b1;
            state_in   = ST_EXP;
         end
         ST_EXP: begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_TIMEOUT;
            rsp_slot_in.id    = exp_rdata.id;
            rsp_slot_in.mtype = exp_rdata.mtype;
            exp_raddr  = exp_ptr_ff[IDX_W-1:0];
            exp_ptr_in = exp_ptr_ff + 1'b1;
            if (exp_ptr_ff == nexp_ff) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_DONE;
            rsp_status_in = fin_status_ff;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         last_time_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         last_time_ff <= last_time_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      key_id_ff     <= key_id_in;
      key_type_ff   <= key_type_in;
      elapsed_ff    <= elapsed_in;
      rd_ptr_ff     <= rd_ptr_in;
      rd_idx_ff     <= rd_idx_in;
      wr_ptr_ff     <= wr_ptr_in;
      found_ff      <= found_in;
      nexp_ff       <= nexp_in;
      exp_ptr_ff    <= exp_ptr_in;
      fin_status_ff <= fin_status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // a last beat retires the item; busy falls with it, but a pop stays busy until its shift is done
   assign busy           = (state_ff != ST_IDLE) || (rsp_valid_ff && !rsp_last_ff);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_entry_id   = rsp_slot_ff.id;
   assign rsp_entry_type = rsp_slot_ff.mtype;
   assign rsp_sends_left = rsp_slot_ff.sends;
   assign rsp_wait_left  = rsp_slot_ff.wait_t;
   assign rsp_status     = rsp_status_ff;
   assign rsp_is_empty   = (total_ff == '0);
   assign rsp_last       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(DEPTH)) else $error("entry count above depth");
   a_busy_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy || (rsp_valid && rsp_last)) else $error("item lost");
   // a pop reports the head while the rest of the table still shifts up
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> state_ff == ST_IDLE ||
         (state_ff == ST_WALK && func_ff == FUNC_POP)) else $error("last beat early");
   a_nexp_bound: assert property (@(posedge clock) disable iff (reset)
      nexp_ff <= CNT_W'(DEPTH)) else $error("expired count overflow");
endmodule

// File: hdl/rtt_slot_ram.sv
module rtt_slot_ram (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [rtt_pkg::IDX_W-1:0] wr_addr,
   input  rtt_pkg::slot_type    wr_data,
   input  logic [rtt_pkg::IDX_W-1:0] rd_addr,
   output rtt_pkg::slot_type    rd_data
);
   import rtt_pkg::*;

   slot_type mem [DEPTH];
   slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hdl/rtt_exp_ram.sv
module rtt_exp_ram (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [rtt_pkg::IDX_W-1:0] wr_addr,
   input  rtt_pkg::expired_type wr_data,
   input  logic [rtt_pkg::IDX_W-1:0] rd_addr,
   output rtt_pkg::expired_type rd_data
);
   import rtt_pkg::*;

   expired_type mem [DEPTH];
   expired_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: bench/retransmit_timer_table_tb.sv
`timescale 1ns / 100ps

module retransmit_timer_table_tb;
   import rtt_pkg::*;

   // one request beat as the driver presents it
   typedef struct {
      logic [2:0]  func;
      logic [15:0] packet_id;
      logic [3:0]  msg_type;
      logic [7:0]  send_count;
      logic [31:0] initial_wait;
      logic [31:0] reload_time;
      logic [31:0] sys_time;
      bit          drain;     // sender holds off until every result has come
   } table_op_type;

   // one response beat
   typedef struct {
      logic [2:0]  kind;
      logic [15:0] entry_id;
      logic [3:0]  entry_type;
      logic [7:0]  sends_left;
      logic [31:0] wait_left;
      logic [1:0]  status;
      logic        is_empty;
      logic        last;
   } table_rsp_type;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_func;
   logic [15:0] req_packet_id;
   logic [3:0]  req_msg_type;
   logic [7:0]  req_send_count;
   logic [31:0] req_initial_wait;
   logic [31:0] req_reload_time;
   logic [31:0] req_sys_time;
   logic        rsp_valid;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_entry_id;
   logic [3:0]  rsp_entry_type;
   logic [7:0]  rsp_sends_left;
   logic [31:0] rsp_wait_left;
   logic [1:0]  rsp_status;
   logic        rsp_is_empty;
   logic        rsp_last;

   retransmit_timer_table dut (.*);

   // predictor state: the in-flight table and the stored time
   slot_type    model_slots[$];
   logic [31:0] model_last_time;

   table_op_type  pending_ops[$];
   table_rsp_type expected_rsps[$];
   int          error_count;
   int          cycle_count;
   bit          quiet_stretch;    // no sender gaps while set
   bit          draining;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic table_rsp_type mk_rsp(logic [2:0] kind, logic [15:0] id,
         logic [3:0] mt, logic [7:0] sends, logic [31:0] wt, logic [1:0] st,
         logic lst);
      table_rsp_type r;
      r.kind = kind; r.entry_id = id; r.entry_type = mt; r.sends_left = sends;
      r.wait_left = wt; r.status = st; r.is_empty = 1'b0; r.last = lst;
      return r;
   endfunction

   function automatic int find_slot(logic [15:0] id, logic [3:0] mt);
      foreach (model_slots[i])
         if (model_slots[i].id == id && model_slots[i].mtype == mt) return i;
      return -1;
   endfunction

   // apply one operation to the table copy and queue the results it causes
   function automatic void predict_table_op(table_op_type op);
      table_rsp_type rs[$];
      slot_type    s;
      slot_type    kept[$];
      expired_type gone[$];
      expired_type e;
      logic [31:0] elapsed;
      logic [7:0]  dec;
      int          pos;
      case (op.func)
         FUNC_CLEAR: begin
            model_slots.delete();
            model_last_time = op.sys_time;
            rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_OK, 1'b1));
         end
         FUNC_PUSH: begin
            if (model_slots.size() >= DEPTH) begin
               rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_FULL, 1'b1));
            end else begin
               s.id = op.packet_id; s.mtype = op.msg_type;
               s.wait_t = op.initial_wait; s.sends = op.send_count;
               s.reload = op.reload_time;
               model_slots.push_back(s);
               rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_OK, 1'b1));
            end
         end
         FUNC_POP: begin
            if (model_slots.size() == 0) begin
               rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_NOTFOUND, 1'b1));
            end else begin
               s = model_slots.pop_front();
               rs.push_back(mk_rsp(KIND_POPPED, s.id, s.mtype, s.sends, s.wait_t,
                                   STAT_OK, 1'b1));
            end
         end
         FUNC_SEARCH: begin
            pos = find_slot(op.packet_id, op.msg_type);
            if (pos < 0) begin
               rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_NOTFOUND, 1'b1));
            end else begin
               s = model_slots[pos];
               rs.push_back(mk_rsp(KIND_FOUND, s.id, s.mtype, s.sends, s.wait_t,
                                   STAT_OK, 1'b1));
            end
         end
         FUNC_REMOVE: begin
            pos = find_slot(op.packet_id, op.msg_type);
            if (pos < 0) begin
               rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_NOTFOUND, 1'b1));
            end else begin
               model_slots.delete(pos);
               rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_OK, 1'b1));
            end
         end
         FUNC_TICK: begin
            // wrap rule: a time behind the stored one counts from all ones
            if (model_last_time <= op.sys_time)
               elapsed = op.sys_time - model_last_time;
            else
               elapsed = TIME_MAX - model_last_time + op.sys_time;
            model_last_time = op.sys_time;
            foreach (model_slots[i]) begin
               s = model_slots[i];
               if (elapsed >= s.wait_t) begin
                  dec = (s.sends != 0) ? s.sends - 8'd1 : 8'd0;
                  if (dec != 0) begin
                     s.sends = dec;
                     s.wait_t = s.reload;
                     rs.push_back(mk_rsp(KIND_RESEND, s.id, s.mtype, s.sends,
                                         s.wait_t, STAT_OK, 1'b0));
                     kept.push_back(s);
                  end else begin
                     e.id = s.id; e.mtype = s.mtype;
                     gone.push_back(e);
                  end
               end else begin
                  s.wait_t = s.wait_t - elapsed;
                  kept.push_back(s);
               end
            end
            model_slots = kept;
            foreach (gone[i])
               rs.push_back(mk_rsp(KIND_TIMEOUT, gone[i].id, gone[i].mtype, 0, 0,
                                   STAT_OK, 1'b0));
            rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_OK, 1'b1));
         end
         default: rs.push_back(mk_rsp(KIND_DONE, 0, 0, 0, 0, STAT_OK, 1'b1));
      endcase
      foreach (rs[i]) begin
         rs[i].is_empty = (model_slots.size() == 0);
         expected_rsps.push_back(rs[i]);
      end
   endfunction

   function automatic table_op_type mk_op(logic [2:0] func, logic [15:0] id,
         logic [3:0] mt, logic [7:0] sends, logic [31:0] wt, logic [31:0] rl,
         logic [31:0] now);
      table_op_type op;
      op.func = func; op.packet_id = id; op.msg_type = mt; op.send_count = sends;
      op.initial_wait = wt; op.reload_time = rl; op.sys_time = now;
      op.drain = 1'b0;
      return op;
   endfunction

   // driver: one beat per start & !busy, random gaps outside the quiet stretch
   always @(posedge clock) begin
      table_op_type op;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         // either nothing is up or the last beat was just taken
         if (pending_ops.size() == 0) begin
            start <= 1'b0;
         end else if (draining && expected_rsps.size() != 0) begin
            start <= 1'b0;
         end else if (pending_ops[0].drain && !draining) begin
            draining = 1'b1;
            start <= 1'b0;
         end else if (!quiet_stretch && $urandom_range(99) < 29) begin
            start <= 1'b0;
         end else begin
            op = pending_ops.pop_front();
            draining = 1'b0;
            start            <= 1'b1;
            req_func         <= op.func;
            req_packet_id    <= op.packet_id;
            req_msg_type     <= op.msg_type;
            req_send_count   <= op.send_count;
            req_initial_wait <= op.initial_wait;
            req_reload_time  <= op.reload_time;
            req_sys_time     <= op.sys_time;
            predict_table_op(op);
         end
      end
   end

   // monitor: results are taken every strobe, oldest expectation first
   always @(posedge clock) begin
      table_rsp_type x;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected result beat kind %0d", rsp_kind);
            error_count++;
         end else begin
            x = expected_rsps.pop_front();
            if (rsp_kind !== x.kind) begin
               $error("kind exp %0d got %0d", x.kind, rsp_kind); error_count++;
            end
            if (rsp_entry_id !== x.entry_id) begin
               $error("entry_id exp %0h got %0h", x.entry_id, rsp_entry_id);
               error_count++;
            end
            if (rsp_entry_type !== x.entry_type) begin
               $error("entry_type exp %0h got %0h", x.entry_type, rsp_entry_type);
               error_count++;
            end
            if (rsp_sends_left !== x.sends_left) begin
               $error("sends_left exp %0d got %0d", x.sends_left, rsp_sends_left);
               error_count++;
            end
            if (rsp_wait_left !== x.wait_left) begin
               $error("wait_left exp %0h got %0h", x.wait_left, rsp_wait_left);
               error_count++;
            end
            if (rsp_status !== x.status) begin
               $error("status exp %0d got %0d", x.status, rsp_status);
               error_count++;
            end
            if (rsp_is_empty !== x.is_empty) begin
               $error("is_empty exp %0d got %0d", x.is_empty, rsp_is_empty);
               error_count++;
            end
            if (rsp_last !== x.last) begin
               $error("last exp %0d got %0d", x.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus
   initial begin
      logic [31:0] now;
      logic [15:0] id;
      logic [3:0]  mt;
      int          sel;
      table_op_type op;
      start = 1'b0;
      req_func = FUNC_CLEAR; req_packet_id = '0; req_msg_type = '0;
      req_send_count = '0; req_initial_wait = '0; req_reload_time = '0;
      req_sys_time = '0;
      error_count = 0; cycle_count = 0;
      quiet_stretch = 0; draining = 0;
      model_last_time = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cases, unknown codes, field extremes, fill past full
      pending_ops.push_back(mk_op(FUNC_POP, 0, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(FUNC_SEARCH, 16'hFFFF, 4'hF, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(FUNC_REMOVE, 0, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(3'd6, 0, 0, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(3'd7, 16'hFFFF, 4'hF, 8'hFF, '1, '1, '1));
      pending_ops.push_back(mk_op(FUNC_CLEAR, 0, 0, 0, 0, 0, 32'hFFFF_FFF0));
      for (int i = 0; i < 17; i++)
         pending_ops.push_back(mk_op(FUNC_PUSH, (i == 0) ? 16'hFFFF : i[15:0],
            (i == 0) ? 4'hF : i[3:0], (i < 3) ? i[7:0] : 8'hFF,
            (i == 1) ? 32'hFFFF_FFFF : 32'(i * 5),
            (i == 2) ? 32'hFFFF_FFFF : 32'd100, 0));
      pending_ops.push_back(mk_op(FUNC_SEARCH, 16'd5, 4'd5, 0, 0, 0, 0));
      pending_ops.push_back(mk_op(FUNC_REMOVE, 16'd5, 4'd5, 0, 0, 0, 0));
      // wraps past all ones: elapsed 0x1F from 0xFFFFFFF0
      pending_ops.push_back(mk_op(FUNC_TICK, 0, 0, 0, 0, 0, 32'h10));
      pending_ops.push_back(mk_op(FUNC_POP, 0, 0, 0, 0, 0, 0));
      op = mk_op(FUNC_TICK, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
      op.drain = 1'b1;
      pending_ops.push_back(op);

      // random: mostly pushes and ticks over a small id set so matches happen
      now = 32'hFFFF_FFFF;
      for (int n = 0; n < 250; n++) begin
         id = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(7));
         mt = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1));
         sel = $urandom_range(99);
         now = now + (($urandom_range(9) == 0) ? $urandom : $urandom_range(60));
         if (sel < 38)
            op = mk_op(FUNC_PUSH, id, mt,
               8'(($urandom_range(4) == 0) ? $urandom : $urandom_range(3)),
               ($urandom_range(9) == 0) ? $urandom : $urandom_range(80),
               ($urandom_range(9) == 0) ? $urandom : $urandom_range(80), $urandom);
         else if (sel < 65)
            op = mk_op(FUNC_TICK, 16'($urandom), 4'($urandom), 8'($urandom),
               $urandom, $urandom, ($urandom_range(19) == 0) ? $urandom : now);
         else if (sel < 74)
            op = mk_op(FUNC_POP, 16'($urandom), 4'($urandom), 8'($urandom),
                       $urandom, $urandom, $urandom);
         else if (sel < 84)
            op = mk_op(FUNC_SEARCH, id, mt, 8'($urandom), $urandom, $urandom,
                       $urandom);
         else if (sel < 94)
            op = mk_op(FUNC_REMOVE, id, mt, 8'($urandom), $urandom, $urandom,
                       $urandom);
         else if (sel < 97)
            op = mk_op(FUNC_CLEAR, 16'($urandom), 4'($urandom), 8'($urandom),
                       $urandom, $urandom, now);
         else
            op = mk_op(3'($urandom_range(7, 6)), 16'($urandom), 4'($urandom),
                       8'($urandom), $urandom, $urandom, $urandom);
         op.drain = ($urandom_range(49) == 0);
         pending_ops.push_back(op);
      end

      // a stretch with no sender gaps in the middle of the random part
      wait (pending_ops.size() < 180);
      quiet_stretch = 1'b1;
      wait (pending_ops.size() < 120);
      quiet_stretch = 1'b0;

      wait (pending_ops.size() == 0 && !(start && busy) && !start);
      wait (expected_rsps.size() == 0);
      repeat (60) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (expected_rsps.size() != 0)
            $error("%0d results never arrived", expected_rsps.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
